>>> hw/rtl/taac_pkg.sv
// ----------------------------------------------------------------------------
// taac_pkg
// Shared constants, register codes and stage control types of the temporal
// anti-aliasing neighbourhood clamp.
// ----------------------------------------------------------------------------
package taac_pkg;

    localparam int DEF_MAX_WIDTH     = 2048;
    localparam int DEF_CHANNEL_BITS  = 10;

    localparam int MAX_HEIGHT        = 4096;
    localparam int ROW_BITS          = 12;
    localparam int MIN_GEOMETRY      = 2;

    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 13;
    localparam int LINE_WIDTH_BITS   = 12;
    localparam int FRAME_HEIGHT_BITS = 13;
    localparam int WEIGHT_BITS       = 9;

    localparam int RST_LINE_WIDTH    = 1920;
    localparam int RST_FRAME_HEIGHT  = 1080;
    localparam int RST_WEIGHT        = 230;
    localparam int WEIGHT_ONE        = 256;

    localparam int BLEND_ROUND       = 128;
    localparam int BLEND_SHIFT       = 8;

    localparam int NUM_RESULTS       = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LINE_WIDTH     = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_HISTORY_WEIGHT = 2'd2
    } t_cfg_reg;

    // control of an item entering the window stage
    typedef struct packed {
        logic                   valid;
        logic                   first_col;
        logic [NUM_RESULTS-1:0] emit;
    } t_win_ctrl;

    // control of an item in the result stages
    typedef struct packed {
        logic                   valid;
        logic [NUM_RESULTS-1:0] emit;
    } t_res_ctrl;

endpackage

>>> hw/rtl/temporal_aa_neighborhood_clamp.sv
// ----------------------------------------------------------------------------
// temporal_aa_neighborhood_clamp
// Temporal anti-aliasing: 3x3 neighbourhood clamp of the history colour and
// blend with the current colour over a raster pixel stream.
// ----------------------------------------------------------------------------
// pipeline: an accepted item passes the line store read, window, column box,
//   clamp, blend and output registers, to its first result on the output
// throughput: one item per cycle while items give at most one result and the
//   output is ready; an item flushing at a line or frame end holds the input
// reset: synchronous; clears counters, window and pipeline control, loads the
//   default geometry and weight; the line store is not cleared
module temporal_aa_neighborhood_clamp #(
    parameter int MAX_WIDTH    = taac_pkg::DEF_MAX_WIDTH,
    parameter int CHANNEL_BITS = taac_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // cur_red, cur_green, cur_blue, hist_red, hist_green, hist_blue, zero pad
    input  logic [((6 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // start_of_frame
    input  logic                                        i_s_axis_tuser,
    output logic                                        o_m_axis_tvalid,
    input  logic                                        i_m_axis_tready,
    // out_red, out_green, out_blue, zero pad
    output logic [((3 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // last_of_run
    output logic                                        o_m_axis_tlast,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [taac_pkg::CFG_INDEX_BITS-1:0]         i_cfg_index,
    input  logic [taac_pkg::CFG_DATA_BITS-1:0]          i_cfg_data
);
    import taac_pkg::*;

    localparam int CB    = CHANNEL_BITS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CMPW  = (CW + 1 > LINE_WIDTH_BITS) ? CW + 1 : LINE_WIDTH_BITS;
    localparam int OUTW  = ((3 * CHANNEL_BITS + 7) / 8) * 8;
    localparam int RST_LAST_COL =
        ((RST_LINE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_LINE_WIDTH) - 1;
    localparam int ENT_HIST = 0;
    localparam int ENT_MID  = 1;
    localparam int ENT_UP   = 2;

    // configuration
    logic [CW-1:0]          r_last_col, n_last_col;
    logic [ROW_BITS-1:0]    r_last_row, n_last_row;
    logic [WEIGHT_BITS-1:0] r_weight, n_weight;
    logic [CMPW-1:0]        lw_ext, lw_clamp;
    logic [FRAME_HEIGHT_BITS-1:0] fh, fh_clamp;
    logic [WEIGHT_BITS-1:0] wt;
    logic                   cfg_wr;

    // input stage
    logic                   adv, accept;
    logic [2:0][CB-1:0]     in_cur, in_hist;
    logic [CW-1:0]          r_col, n_col, c_raw, c;
    logic [ROW_BITS-1:0]    r_row, n_row, row_raw, row;
    logic                   at_last_col, at_last_row;

    // line store stage
    logic                   r_s1_valid, r_s1_first, r_s1_rge1, r_s1_rge2;
    logic [NUM_RESULTS-1:0] r_s1_emit;
    logic [CW-1:0]          r_s1_addr;
    logic [2:0][CB-1:0]     r_s1_cur, r_s1_hist;
    t_win_ctrl              s1_ctrl;
    logic [2:0][2:0][CB-1:0] old_entry, wr_entry;
    logic [2:0][CB-1:0]     s1_mid, s1_top, s1_hup;
    logic                   wr_en;

    t_res_ctrl                            res_ctrl;
    logic [NUM_RESULTS-1:0][2:0][CB-1:0]  res_center, res_clamp;
    logic [2:0][CB-1:0]                   out_data;

    // ---------------- configuration registers ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        lw_ext = CMPW'(i_cfg_data[LINE_WIDTH_BITS-1:0]);
        if (lw_ext < CMPW'(MIN_GEOMETRY)) begin
            lw_clamp = CMPW'(MIN_GEOMETRY);
        end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
            lw_clamp = CMPW'(MAX_WIDTH);
        end else begin
            lw_clamp = lw_ext;
        end
        n_last_col = CW'(lw_clamp - CMPW'(1));

        fh = i_cfg_data[FRAME_HEIGHT_BITS-1:0];
        if (fh < FRAME_HEIGHT_BITS'(MIN_GEOMETRY)) begin
            fh_clamp = FRAME_HEIGHT_BITS'(MIN_GEOMETRY);
        end else if (fh > FRAME_HEIGHT_BITS'(MAX_HEIGHT)) begin
            fh_clamp = FRAME_HEIGHT_BITS'(MAX_HEIGHT);
        end else begin
            fh_clamp = fh;
        end
        n_last_row = ROW_BITS'(fh_clamp - FRAME_HEIGHT_BITS'(1));

        wt       = i_cfg_data[WEIGHT_BITS-1:0];
        n_weight = (wt > WEIGHT_BITS'(WEIGHT_ONE)) ? WEIGHT_BITS'(WEIGHT_ONE) : wt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= CW'(RST_LAST_COL);
            r_last_row <= ROW_BITS'(RST_FRAME_HEIGHT - 1);
            r_weight   <= WEIGHT_BITS'(RST_WEIGHT);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_LINE_WIDTH:     r_last_col <= n_last_col;
                REG_FRAME_HEIGHT:   r_last_row <= n_last_row;
                REG_HISTORY_WEIGHT: r_weight   <= n_weight;
                default: ;
            endcase
        end
    end

    // ---------------- raster position ----------------
    assign accept          = i_s_axis_tvalid && adv;
    assign o_s_axis_tready = adv;
    assign in_cur          = i_s_axis_tdata[3*CB-1:0];
    assign in_hist         = i_s_axis_tdata[6*CB-1:3*CB];

    always_comb begin
        c_raw   = i_s_axis_tuser ? '0 : r_col;
        row_raw = i_s_axis_tuser ? '0 : r_row;
        // a position left beyond the geometry counts as the last column or row
        c   = (c_raw > r_last_col) ? r_last_col : c_raw;
        row = (row_raw > r_last_row) ? r_last_row : row_raw;
        at_last_col = (c == r_last_col);
        at_last_row = (row == r_last_row);
        if (at_last_col) begin
            n_col = '0;
            n_row = at_last_row ? '0 : row + ROW_BITS'(1);
        end else begin
            n_col = c + CW'(1);
            n_row = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (adv) begin
                r_s1_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr    <= c;
            r_s1_cur     <= in_cur;
            r_s1_hist    <= in_hist;
            r_s1_first   <= (c == '0);
            r_s1_rge1    <= (row != '0);
            r_s1_rge2    <= (row[ROW_BITS-1:1] != '0);
            r_s1_emit[0] <= (row != '0) && (c != '0);
            r_s1_emit[1] <= (row != '0) && at_last_col;
            r_s1_emit[2] <= at_last_row && (c != '0);
            r_s1_emit[3] <= at_last_row && at_last_col;
        end
    end

    // ---------------- line store read-modify-write ----------------
    taac_line_store #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_rd_addr (c),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_entry),
        .o_rd_data (old_entry)
    );

    // rows not yet seen in this frame are replaced by the row below
    always_comb begin
        s1_mid = r_s1_rge1 ? old_entry[ENT_MID]  : r_s1_cur;
        s1_top = r_s1_rge2 ? old_entry[ENT_UP]   : s1_mid;
        s1_hup = r_s1_rge1 ? old_entry[ENT_HIST] : r_s1_hist;
        wr_entry[ENT_UP]   = old_entry[ENT_MID];
        wr_entry[ENT_MID]  = r_s1_cur;
        wr_entry[ENT_HIST] = r_s1_hist;
    end

    assign wr_en   = adv && r_s1_valid;
    assign s1_ctrl = '{valid: r_s1_valid, first_col: r_s1_first, emit: r_s1_emit};

    // ---------------- window, box and clamp ----------------
    taac_window #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_ctrl   (s1_ctrl),
        .i_top    (s1_top),
        .i_mid    (s1_mid),
        .i_cur    (r_s1_cur),
        .i_hup    (s1_hup),
        .i_hist   (r_s1_hist),
        .o_ctrl   (res_ctrl),
        .o_center (res_center),
        .o_clamp  (res_clamp)
    );

    // ---------------- blend and output ----------------
    taac_blend_out #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_blend_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (res_ctrl),
        .i_center (res_center),
        .i_clamp  (res_clamp),
        .i_weight (r_weight),
        .i_tready (i_m_axis_tready),
        .o_adv    (adv),
        .o_tvalid (o_m_axis_tvalid),
        .o_data   (out_data),
        .o_tlast  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUTW'(out_data);

`ifndef ASSERT_OFF
    // more results of the same item follow directly after a non-final one
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("result run broken before its last item");

    // a frame start lands on the first column and flushes nothing
    a_sof_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_s_axis_tuser |=> r_s1_valid && r_s1_first && (r_s1_emit == '0))
        else $error("frame start not at first column of first row");

    // the line store is written only for an item moving out of the read stage
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_s1_valid && o_s_axis_tready)
        else $error("line store written without an item");
`endif

endmodule

>>> hw/rtl/taac_line_store.sv
// ----------------------------------------------------------------------------
// taac_line_store
// Combined line store: upper line, middle line and delayed history per
// column, one synchronous read on advance and one write a cycle; forwarding.
// ----------------------------------------------------------------------------
module taac_line_store #(
    parameter int MAX_WIDTH    = taac_pkg::DEF_MAX_WIDTH,
    parameter int CHANNEL_BITS = taac_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_adv,
    input  logic [$clog2(MAX_WIDTH)-1:0]            i_rd_addr,
    input  logic                                    i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]            i_wr_addr,
    input  logic [2:0][2:0][CHANNEL_BITS-1:0]       i_wr_data,
    output logic [2:0][2:0][CHANNEL_BITS-1:0]       o_rd_data
);
    import taac_pkg::*;

    logic [2:0][2:0][CHANNEL_BITS-1:0] mem [MAX_WIDTH];
    logic [2:0][2:0][CHANNEL_BITS-1:0] r_rdata;
    logic [2:0][2:0][CHANNEL_BITS-1:0] r_fwd_data;
    logic                              r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_adv) begin
            r_rdata    <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // read of the entry being written in the same cycle returns the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_adv) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rdata;

endmodule

>>> hw/rtl/taac_window.sv
// ----------------------------------------------------------------------------
// taac_window
// 3x3 window and history registers, per-column minimum and maximum, then the
// four neighbourhood boxes and the history clamp.
// ----------------------------------------------------------------------------
module taac_window #(
    parameter int CHANNEL_BITS = taac_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_adv,
    input  taac_pkg::t_win_ctrl                           i_ctrl,
    input  logic [2:0][CHANNEL_BITS-1:0]                  i_top,
    input  logic [2:0][CHANNEL_BITS-1:0]                  i_mid,
    input  logic [2:0][CHANNEL_BITS-1:0]                  i_cur,
    input  logic [2:0][CHANNEL_BITS-1:0]                  i_hup,
    input  logic [2:0][CHANNEL_BITS-1:0]                  i_hist,
    output taac_pkg::t_res_ctrl                           o_ctrl,
    output logic [taac_pkg::NUM_RESULTS-1:0][2:0][CHANNEL_BITS-1:0] o_center,
    output logic [taac_pkg::NUM_RESULTS-1:0][2:0][CHANNEL_BITS-1:0] o_clamp
);
    import taac_pkg::*;

    localparam int CB = CHANNEL_BITS;

    logic [2:0][2:0][CB-1:0]          rowin;
    logic [8:0][2:0][CB-1:0]          r_win;
    logic [3:0][2:0][CB-1:0]          r_hreg;
    t_res_ctrl                        r_wctl;

    logic [2:0][2:0][CB-1:0]          n_cmin3, n_cmax3, n_cmin2, n_cmax2;
    logic [2:0][2:0][CB-1:0]          r_cmin3, r_cmax3, r_cmin2, r_cmax2;
    logic [NUM_RESULTS-1:0][2:0][CB-1:0] r_cctr, r_chist;
    t_res_ctrl                        r_cctl;

    logic [NUM_RESULTS-1:0][2:0][CB-1:0] n_kclamp;
    logic [NUM_RESULTS-1:0][2:0][CB-1:0] r_kctr, r_kclamp;
    t_res_ctrl                        r_kctl;

    assign rowin[0] = i_top;
    assign rowin[1] = i_mid;
    assign rowin[2] = i_cur;

    // window shift, or fill by replication at the first column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_hreg <= '0;
        end else if (i_adv && i_ctrl.valid) begin
            for (int i = 0; i < 3; i++) begin
                if (i_ctrl.first_col) begin
                    r_win[i*3]     <= rowin[i];
                    r_win[i*3 + 1] <= rowin[i];
                    r_win[i*3 + 2] <= rowin[i];
                end else begin
                    r_win[i*3]     <= r_win[i*3 + 1];
                    r_win[i*3 + 1] <= r_win[i*3 + 2];
                    r_win[i*3 + 2] <= rowin[i];
                end
            end
            if (i_ctrl.first_col) begin
                r_hreg[0] <= i_hup;
                r_hreg[1] <= i_hup;
                r_hreg[2] <= i_hist;
                r_hreg[3] <= i_hist;
            end else begin
                r_hreg[0] <= r_hreg[1];
                r_hreg[1] <= i_hup;
                r_hreg[2] <= r_hreg[3];
                r_hreg[3] <= i_hist;
            end
        end
    end

    // per column: rows 0..2 and rows 1..2
    always_comb begin
        logic [CB-1:0] lo2, hi2;
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                lo2 = (r_win[3 + j][k] < r_win[6 + j][k]) ? r_win[3 + j][k] : r_win[6 + j][k];
                hi2 = (r_win[3 + j][k] > r_win[6 + j][k]) ? r_win[3 + j][k] : r_win[6 + j][k];
                n_cmin2[j][k] = lo2;
                n_cmax2[j][k] = hi2;
                n_cmin3[j][k] = (r_win[j][k] < lo2) ? r_win[j][k] : lo2;
                n_cmax3[j][k] = (r_win[j][k] > hi2) ? r_win[j][k] : hi2;
            end
        end
    end

    // box per result: upper results take all rows, odd ones drop column 0
    always_comb begin
        logic [CB-1:0] lo, hi, h, a, b;
        for (int n = 0; n < NUM_RESULTS; n++) begin
            for (int k = 0; k < 3; k++) begin
                if (n < 2) begin
                    a  = (r_cmin3[1][k] < r_cmin3[2][k]) ? r_cmin3[1][k] : r_cmin3[2][k];
                    b  = (r_cmax3[1][k] > r_cmax3[2][k]) ? r_cmax3[1][k] : r_cmax3[2][k];
                    lo = (((n & 1) == 0) && (r_cmin3[0][k] < a)) ? r_cmin3[0][k] : a;
                    hi = (((n & 1) == 0) && (r_cmax3[0][k] > b)) ? r_cmax3[0][k] : b;
                end else begin
                    a  = (r_cmin2[1][k] < r_cmin2[2][k]) ? r_cmin2[1][k] : r_cmin2[2][k];
                    b  = (r_cmax2[1][k] > r_cmax2[2][k]) ? r_cmax2[1][k] : r_cmax2[2][k];
                    lo = (((n & 1) == 0) && (r_cmin2[0][k] < a)) ? r_cmin2[0][k] : a;
                    hi = (((n & 1) == 0) && (r_cmax2[0][k] > b)) ? r_cmax2[0][k] : b;
                end
                h = r_chist[n][k];
                if (h < lo) begin
                    h = lo;
                end
                if (h > hi) begin
                    h = hi;
                end
                n_kclamp[n][k] = h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wctl <= '0;
            r_cctl <= '0;
            r_kctl <= '0;
        end else if (i_adv) begin
            r_wctl <= '{valid: i_ctrl.valid, emit: i_ctrl.emit};
            r_cctl <= r_wctl;
            r_kctl <= r_cctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cmin3   <= n_cmin3;
            r_cmax3   <= n_cmax3;
            r_cmin2   <= n_cmin2;
            r_cmax2   <= n_cmax2;
            r_cctr[0] <= r_win[4];
            r_cctr[1] <= r_win[5];
            r_cctr[2] <= r_win[7];
            r_cctr[3] <= r_win[8];
            r_chist   <= r_hreg;
            r_kctr    <= r_cctr;
            r_kclamp  <= n_kclamp;
        end
    end

    assign o_ctrl   = r_kctl;
    assign o_center = r_kctr;
    assign o_clamp  = r_kclamp;

endmodule

>>> hw/rtl/taac_blend_out.sv
// ----------------------------------------------------------------------------
// taac_blend_out
// History blend of up to four results per item, and the output register that
// hands them out one per cycle unless stalled; also gives pipeline advance.
// ----------------------------------------------------------------------------
module taac_blend_out #(
    parameter int CHANNEL_BITS = taac_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  taac_pkg::t_res_ctrl                                     i_ctrl,
    input  logic [taac_pkg::NUM_RESULTS-1:0][2:0][CHANNEL_BITS-1:0] i_center,
    input  logic [taac_pkg::NUM_RESULTS-1:0][2:0][CHANNEL_BITS-1:0] i_clamp,
    input  logic [taac_pkg::WEIGHT_BITS-1:0]                        i_weight,
    input  logic                                                    i_tready,
    output logic                                                    o_adv,
    output logic                                                    o_tvalid,
    output logic [2:0][CHANNEL_BITS-1:0]                            o_data,
    output logic                                                    o_tlast
);
    import taac_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int PW = CHANNEL_BITS + WEIGHT_BITS + 2;
    localparam logic signed [PW-1:0] RND = PW'(BLEND_ROUND);

    logic [NUM_RESULTS-1:0][2:0][CB-1:0] n_res, r_res;
    logic [NUM_RESULTS-1:0]              r_pend, low, rest;
    logic [$clog2(NUM_RESULTS)-1:0]      sel;
    logic                                out_free;
    logic signed [WEIGHT_BITS:0]         wgt_s;
    logic [2:0][CB-1:0]                  r_odata;
    logic                                r_ovalid, r_olast;

    assign wgt_s = $signed({1'b0, i_weight});

    // cur + ((clamped - cur) * w + round) >> 8, same as the two-term blend
    always_comb begin
        logic signed [CB:0]   diff;
        logic signed [PW-1:0] acc;
        logic signed [PW-1:0] blend_v;
        for (int n = 0; n < NUM_RESULTS; n++) begin
            for (int k = 0; k < 3; k++) begin
                diff = $signed({1'b0, i_clamp[n][k]}) - $signed({1'b0, i_center[n][k]});
                acc  = PW'(diff) * PW'(wgt_s);
                acc  = acc + RND;
                blend_v = $signed(PW'({1'b0, i_center[n][k]})) + (acc >>> BLEND_SHIFT);
                n_res[n][k] = blend_v[CB-1:0];
            end
        end
    end

    assign out_free = !r_ovalid || i_tready;
    assign low      = r_pend & (~r_pend + NUM_RESULTS'(1));
    assign rest     = r_pend & ~low;
    // new item may enter once at most one result is left and it goes now
    assign o_adv    = out_free ? ((r_pend & (r_pend - NUM_RESULTS'(1))) == '0)
                               : (r_pend == '0);

    always_comb begin
        priority if (r_pend[0]) begin
            sel = 2'd0;
        end else if (r_pend[1]) begin
            sel = 2'd1;
        end else if (r_pend[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_pend <= i_ctrl.valid ? i_ctrl.emit : '0;
            end else if (out_free) begin
                r_pend <= rest;
            end
            if (out_free) begin
                r_ovalid <= (r_pend != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_res <= n_res;
        end
        if (out_free && (r_pend != '0)) begin
            r_odata <= r_res[sel];
            r_olast <= (rest == '0);
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_data   = r_odata;
    assign o_tlast  = r_olast;

endmodule
